[hw/rtl/wsa_pkg.sv]
package wsa_pkg;

  typedef logic signed [23:0] score_t;
  typedef logic signed [15:0] weight_t;

  localparam score_t SCORE_MAX = 24'sh7FFFFF;
  localparam score_t SCORE_MIN = 24'sh800000;

  // item commands
  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_REF    = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_FINISH = 2'd3
  } command_t;

  // scoring modes (code 3 scores as edit distance)
  localparam logic [1:0] MODE_EDIT   = 2'd0;
  localparam logic [1:0] MODE_GLOBAL = 2'd1;
  localparam logic [1:0] MODE_LOCAL  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_MISSING = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_GAP      = 3'd1;
  localparam logic [2:0] REG_MATCH    = 3'd2;
  localparam logic [2:0] REG_MISMATCH = 3'd3;
  localparam logic [2:0] REG_ALPHABET = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    weight_t    gap_cost;
    weight_t    match_cost;
    weight_t    mismatch_cost;
    logic [4:0] alphabet_size;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT0,
    S_INIT1,
    S_LREF,
    S_LTBL,
    S_LCELL,
    S_QCHECK,
    S_QROW0,
    S_FREAD,
    S_FOUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    state_t phase;
    logic   accept;
    logic   loop_init;
    logic   out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic qc_zero;
    logic ref_empty;
    logic j_last;
    logic q_abort;
    logic out_stall;
  } dp_status_t;

  function automatic score_t sx16(input weight_t w);
    return {{8{w[15]}}, w};
  endfunction

  function automatic score_t sat_add(input score_t a, input score_t b);
    logic signed [24:0] s;
    s = {a[23], a} + {b[23], b};
    if (s[24] != s[23]) begin
      return s[24] ? SCORE_MIN : SCORE_MAX;
    end
    return s[23:0];
  endfunction

  function automatic score_t sat_neg(input score_t a);
    if (a == SCORE_MIN) begin
      return SCORE_MAX;
    end
    return -a;
  endfunction

endpackage

[hw/rtl/wsa_chan_if.sv]
interface wsa_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  symbol;
  logic        symbol_missing;
  logic        start_req;
  logic [3:0]  table_row;
  logic [3:0]  table_col;
  logic signed [15:0] weight;

  modport source (output valid, command, symbol, symbol_missing, start_req,
                  table_row, table_col, weight, input ready);
  modport sink (input valid, command, symbol, symbol_missing, start_req,
                table_row, table_col, weight, output ready);
endinterface

interface wsa_result_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] score;
  logic [1:0]  status;

  modport source (output valid, score, status, input ready);
  modport sink (input valid, score, status, output ready);
endinterface

[hw/rtl/wsa_ram.sv]
module wsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/wsa_ctrl.sv]
module wsa_ctrl import wsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [1:0] item_command,
  output logic       item_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;
  logic   loop_init, loop_init_next;
  logic   ret_fin, ret_fin_next;
  state_t after_init;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      loop_init <= 1'b0;
      ret_fin   <= 1'b0;
    end else begin
      state     <= state_next;
      loop_init <= loop_init_next;
      ret_fin   <= ret_fin_next;
    end
  end

  always_comb begin
    state_next     = state;
    loop_init_next = loop_init;
    ret_fin_next   = ret_fin;
    after_init     = ret_fin ? S_FREAD : S_QCHECK;
    item_ready     = (state == S_IDLE);
    cmd.phase      = state;
    cmd.accept     = item_ready && item_valid;
    cmd.loop_init  = loop_init;
    cmd.out_load   = 1'b0;

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (command_t'(item_command))
            CMD_QUERY: begin
              ret_fin_next = 1'b0;
              state_next   = status.qc_zero ? S_INIT0 : S_QCHECK;
            end
            CMD_FINISH: begin
              ret_fin_next = 1'b1;
              state_next   = status.qc_zero ? S_INIT0 : S_FREAD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INIT0: state_next = S_INIT1;
      S_INIT1: begin
        loop_init_next = 1'b1;
        state_next     = status.ref_empty ? after_init : S_LREF;
      end
      S_LREF: state_next = S_LTBL;
      S_LTBL: state_next = S_LCELL;
      S_LCELL: begin
        if (status.j_last) begin
          state_next = loop_init ? after_init : S_IDLE;
        end else begin
          state_next = S_LREF;
        end
      end
      S_QCHECK: state_next = status.q_abort ? S_IDLE : S_QROW0;
      S_QROW0: begin
        loop_init_next = 1'b0;
        state_next     = status.ref_empty ? S_IDLE : S_LREF;
      end
      S_FREAD: state_next = S_FOUT;
      S_FOUT: begin
        // hold the result until the output register frees up
        if (!status.out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/wsa_datapath.sv]
module wsa_datapath import wsa_pkg::*; #(
  parameter int MAX_LEN      = 256,
  parameter int MAX_ALPHABET = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic [1:0]  item_command,
  input  logic [7:0]  item_symbol,
  input  logic        item_missing,
  input  logic        item_start,
  input  logic [3:0]  item_row,
  input  logic [3:0]  item_col,
  input  weight_t     item_weight,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        res_valid,
  input  logic        res_ready,
  output score_t      res_score,
  output logic [1:0]  res_status
);

  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int RAW = $clog2(MAX_LEN);
  localparam int TD  = MAX_ALPHABET * MAX_ALPHABET;
  localparam int TAW = $clog2(TD);

  // pair state
  logic [LW-1:0] rc, qc, j;
  score_t        best, last, diag, left;
  logic [1:0]    err;
  // per-item working registers
  logic [7:0]    x_sym;
  logic          x_missing;
  score_t        w1x;
  logic          va, vb;

  // memory ports
  logic           ref_we, ref_re;
  logic [RAW-1:0] ref_waddr, ref_raddr;
  logic [7:0]     ref_rdata;
  logic           row_we, row_re;
  logic [LW-1:0]  row_waddr, row_raddr;
  score_t         row_wdata;
  logic [23:0]    row_rdata;
  logic           tbl_we;
  logic [TAW-1:0] tbl_waddr, tbla_raddr, tblb_raddr;
  logic [15:0]    tbla_rdata, tblb_rdata;
  logic           tbla_re, tblb_re;

  logic           m1, m2, m12;
  logic [LW-1:0]  rc_eff;
  logic           append_ok, tbl_ok;
  score_t         up, wa, wb, s0, s1, s2, cell_score, init_val, last_n;
  logic [7:0]     y;
  logic           x_ok, y_ok;
  logic [1:0]     fin_status;
  score_t         fin_score;

  function automatic logic code_ok(input logic [7:0] s);
    return (s != 8'd0) && ({8'd0, s} <= 16'(MAX_ALPHABET));
  endfunction

  function automatic logic in_alpha(input logic [7:0] s, input logic [4:0] a);
    logic [15:0] eff;
    eff = (16'(a) > 16'(MAX_ALPHABET)) ? 16'(MAX_ALPHABET) : 16'(a);
    return (s != 8'd0) && ({8'd0, s} <= eff);
  endfunction

  function automatic logic [TAW-1:0] tidx(input logic [7:0] r, input logic [7:0] q);
    logic [15:0] t;
    t = 16'(r - 8'd1) * 16'(MAX_ALPHABET) + 16'(q - 8'd1);
    return t[TAW-1:0];
  endfunction

  assign m1  = (cfg.mode == MODE_GLOBAL);
  assign m2  = (cfg.mode == MODE_LOCAL);
  assign m12 = m1 || m2;

  wsa_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ref (
    .clk, .we(ref_we), .waddr(ref_waddr), .wdata(item_symbol),
    .re(ref_re), .raddr(ref_raddr), .rdata(ref_rdata)
  );

  wsa_ram #(.WIDTH(24), .DEPTH(MAX_LEN + 1)) u_row (
    .clk, .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .re(row_re), .raddr(row_raddr), .rdata(row_rdata)
  );

  // two copies of the weight table so a cell reads (y,x) and (y,gap) at once
  wsa_ram #(.WIDTH(16), .DEPTH(TD)) u_tbla (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(item_weight),
    .re(tbla_re), .raddr(tbla_raddr), .rdata(tbla_rdata)
  );

  wsa_ram #(.WIDTH(16), .DEPTH(TD)) u_tblb (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(item_weight),
    .re(tblb_re), .raddr(tblb_raddr), .rdata(tblb_rdata)
  );

  // append and table write decode
  assign rc_eff    = item_start ? '0 : rc;
  assign append_ok = (item_start || qc == '0) && !item_missing && (rc_eff < LW'(MAX_LEN));
  assign tbl_ok    = (16'(item_row) < 16'(MAX_ALPHABET)) && (16'(item_col) < 16'(MAX_ALPHABET));
  assign ref_we    = cmd.accept && (item_command == CMD_REF) && append_ok;
  assign ref_waddr = rc_eff[RAW-1:0];
  assign tbl_we    = cmd.accept && (item_command == CMD_WEIGHT) && tbl_ok;
  assign tbl_waddr = TAW'(16'(item_row) * 16'(MAX_ALPHABET) + 16'(item_col));

  // read data views
  assign y    = ref_rdata;
  assign up   = $signed(row_rdata);
  assign wa   = va ? sx16($signed(tbla_rdata)) : '0;
  assign wb   = vb ? sx16($signed(tblb_rdata)) : '0;
  assign x_ok = code_ok(x_sym);
  assign y_ok = code_ok(y);

  // cell arithmetic
  always_comb begin
    if (m12) begin
      s0 = sat_add(up, w1x);
      s1 = sat_add(left, wb);
      s2 = sat_add(diag, wa);
      cell_score = (s0 > s1) ? s0 : s1;
      if (s2 > cell_score) cell_score = s2;
      if (m2 && cell_score < 0) cell_score = '0;
    end else begin
      s0 = sat_add(up, sx16(cfg.gap_cost));
      s1 = sat_add(left, sx16(cfg.gap_cost));
      s2 = sat_add(diag, sx16((x_sym == y) ? cfg.match_cost : cfg.mismatch_cost));
      cell_score = (s0 < s1) ? s0 : s1;
      if (s2 < cell_score) cell_score = s2;
    end
    if (m1) init_val = sat_add(left, wb);
    else if (m2) init_val = '0;
    else init_val = sat_add(left, sx16(cfg.gap_cost));
    if (m1) last_n = sat_add(last, wa);
    else if (m2) last_n = '0;
    else last_n = sat_add(last, sx16(cfg.gap_cost));
  end

  // memory addressing by phase
  always_comb begin
    ref_re     = 1'b0;
    ref_raddr  = RAW'(j - LW'(1));
    row_re     = 1'b0;
    row_raddr  = j;
    row_we     = 1'b0;
    row_waddr  = j;
    row_wdata  = cell_score;
    tbla_re    = 1'b0;
    tbla_raddr = tidx(y, x_sym);
    tblb_re    = 1'b0;
    tblb_raddr = tidx(y, 8'd1);
    case (cmd.phase)
      S_INIT0: begin
        tblb_re    = 1'b1;
        tblb_raddr = tidx(8'd1, 8'd1);
      end
      S_INIT1: begin
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = m1 ? wb : '0;
      end
      S_LREF: begin
        ref_re = 1'b1;
        row_re = !cmd.loop_init;
      end
      S_LTBL: begin
        tbla_re = !cmd.loop_init;
        tblb_re = 1'b1;
      end
      S_LCELL: begin
        row_we    = 1'b1;
        row_wdata = cmd.loop_init ? init_val : cell_score;
      end
      S_QCHECK: begin
        tbla_re    = 1'b1;
        tbla_raddr = tidx(8'd1, x_sym);
        row_re     = 1'b1;
        row_raddr  = '0;
      end
      S_QROW0: begin
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = last_n;
      end
      S_FREAD: begin
        row_re    = 1'b1;
        row_raddr = rc;
      end
      default: ;
    endcase
  end

  // finish result
  always_comb begin
    if (err[0]) fin_status = STATUS_MISSING;
    else if (err[1]) fin_status = STATUS_RANGE;
    else fin_status = STATUS_OK;
    if (fin_status != STATUS_OK) fin_score = '0;
    else if (m1) fin_score = sat_neg(up);
    else if (m2) fin_score = sat_neg(best);
    else fin_score = up;
  end

  always_comb begin
    status.qc_zero   = (qc == '0);
    status.ref_empty = (rc == '0);
    status.j_last    = (j == rc);
    status.q_abort   = x_missing || (m12 && !in_alpha(x_sym, cfg.alphabet_size)) ||
                       (err != 2'b00);
    status.out_stall = res_valid && !res_ready;
  end

  // pair state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rc        <= '0;
      qc        <= '0;
      best      <= '0;
      last      <= '0;
      err       <= 2'b00;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (cmd.accept && item_command == CMD_REF) begin
        if (item_start) begin
          rc   <= '0;
          qc   <= '0;
          best <= '0;
          last <= '0;
          err  <= 2'b00;
        end
        if (item_start || qc == '0) begin
          if (item_missing) err <= (item_start ? 2'b00 : err) | 2'b01;
          else if (rc_eff < LW'(MAX_LEN)) rc <= rc_eff + LW'(1);
        end
      end
      case (cmd.phase)
        S_INIT1: begin
          last <= m1 ? wb : '0;
          best <= '0;
        end
        S_LTBL: begin
          // reference range check happens during the init pass
          if (cmd.loop_init && m12 && !in_alpha(y, cfg.alphabet_size)) err[1] <= 1'b1;
        end
        S_LCELL: begin
          if (!cmd.loop_init && m2 && cell_score > best) best <= cell_score;
        end
        S_QCHECK: begin
          if (qc < LW'(MAX_LEN)) qc <= qc + LW'(1);
          if (x_missing) err[0] <= 1'b1;
          else if (m12 && !in_alpha(x_sym, cfg.alphabet_size)) err[1] <= 1'b1;
        end
        S_QROW0: last <= last_n;
        default: ;
      endcase
      if (cmd.out_load) begin
        res_valid <= 1'b1;
        rc        <= '0;
        qc        <= '0;
        best      <= '0;
        last      <= '0;
        err       <= 2'b00;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_sym     <= item_symbol;
      x_missing <= item_missing;
    end
    case (cmd.phase)
      S_INIT0: vb <= 1'b1;
      S_INIT1: begin
        left <= m1 ? wb : '0;
        j    <= LW'(1);
      end
      S_LTBL: begin
        va <= y_ok && x_ok;
        vb <= y_ok;
      end
      S_LCELL: begin
        diag <= up;
        left <= cmd.loop_init ? init_val : cell_score;
        j    <= j + LW'(1);
      end
      S_QCHECK: va <= x_ok;
      S_QROW0: begin
        diag <= up;
        left <= last_n;
        w1x  <= wa;
        j    <= LW'(1);
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      res_score  <= fin_score;
      res_status <= fin_status;
    end
  end

endmodule

[hw/rtl/weighted_sequence_alignment_score.sv]
// Weighted sequence alignment score.
// Items arrive on the item channel (valid/ready). Command 0 writes a weight
// table entry and command 1 appends a reference symbol; both are taken
// without leaving the idle state. Command 2 takes a query symbol and
// updates the stored score row cell by cell. The first query of a pair
// also runs a row initialization pass before its own row update.
// Command 3 (finish) reads the last cell and then loads the result
// register (after the initialization pass when no query came), then
// clears the pair. Each cell is paced by the registered reads of the
// reference memory, then of the weight tables, before the cell update.
// Only finish returns a result, on the result channel. The result register
// holds while the receiver stalls; other commands are still taken, and a
// finish waits in its last state until the register frees.
// Reset clears the pair state and the configuration registers; the memories need no
// clearing pass. Configuration is on the APB port, one register per word.
module weighted_sequence_alignment_score import wsa_pkg::*; #(
  parameter int MAX_LEN      = 256,
  parameter int MAX_ALPHABET = 16
) (
  input  logic              clk,
  input  logic              rst,
  wsa_item_if.sink          item,
  wsa_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= MODE_EDIT;
      cfg.gap_cost      <= 16'sd256;
      cfg.match_cost    <= 16'sd0;
      cfg.mismatch_cost <= 16'sd256;
      cfg.alphabet_size <= 5'd16;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_MODE:     cfg.mode          <= pwdata[1:0];
        REG_GAP:      cfg.gap_cost      <= pwdata[15:0];
        REG_MATCH:    cfg.match_cost    <= pwdata[15:0];
        REG_MISMATCH: cfg.mismatch_cost <= pwdata[15:0];
        REG_ALPHABET: cfg.alphabet_size <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_index)
      REG_MODE:     prdata = {30'd0, cfg.mode};
      REG_GAP:      prdata = {{16{cfg.gap_cost[15]}}, cfg.gap_cost};
      REG_MATCH:    prdata = {{16{cfg.match_cost[15]}}, cfg.match_cost};
      REG_MISMATCH: prdata = {{16{cfg.mismatch_cost[15]}}, cfg.mismatch_cost};
      REG_ALPHABET: prdata = {27'd0, cfg.alphabet_size};
      default:      prdata = 32'd0;
    endcase
  end

  wsa_ctrl u_ctrl (
    .clk,
    .rst,
    .item_valid   (item.valid),
    .item_command (item.command),
    .item_ready   (item.ready),
    .status,
    .cmd
  );

  wsa_datapath #(.MAX_LEN(MAX_LEN), .MAX_ALPHABET(MAX_ALPHABET)) u_dp (
    .clk,
    .rst,
    .cfg,
    .item_command (item.command),
    .item_symbol  (item.symbol),
    .item_missing (item.symbol_missing),
    .item_start   (item.start_req),
    .item_row     (item.table_row),
    .item_col     (item.table_col),
    .item_weight  (item.weight),
    .cmd,
    .status,
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_score    (result.score),
    .res_status   (result.status)
  );

endmodule

[hw/rtl/wsa_checker.sv]
module wsa_checker import wsa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic [1:0]  item_command,
  input logic        result_valid,
  input logic        result_ready,
  input logic [23:0] result_score,
  input logic [1:0]  result_status
);

  // a stalled result keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_score) &&
    $stable(result_status))
    else $error("result changed while stalled");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_status == STATUS_OK || result_status == STATUS_MISSING ||
                      result_status == STATUS_RANGE))
    else $error("undefined status code");

  // an error result carries a zero score
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_status != STATUS_OK |-> result_score == 24'd0)
    else $error("error result with nonzero score");

  // query and finish transactions leave the block busy, so ready drops after them
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item_command == CMD_QUERY || item_command == CMD_FINISH)
    |=> !item_ready)
    else $error("ready right after query or finish");

endmodule

bind weighted_sequence_alignment_score wsa_checker u_wsa_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .item_command  (item.command),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_score  (result.score),
  .result_status (result.status)
);
